@@ sv/dtr_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the divider timer with delayed reload
// no dependencies
package dtr_pkg;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned CD_W    = 3;
    localparam int unsigned TICK_W  = 6;

    localparam logic [CNT_W-1:0] COUNTER_MAX  = 8'hFF;
    localparam logic [CD_W-1:0]  RELOAD_DELAY = 3'd4;

    localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
    localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
    localparam logic [1:0] REG_RELOAD_VALUE = 2'd2;

    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_WRITE   = 1'b1;

    // divider bit whose falling edge clocks the counter
    function automatic logic [3:0] edge_bit(input logic [1:0] sel);
        logic [3:0] b;
        case (sel)
            2'd0:    b = 4'd9;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd5;
            2'd3:    b = 4'd7;
            default: b = 4'd9;
        endcase
        return b;
    endfunction

endpackage

@@ sv/divider_timer_with_delayed_reload.sv @@
`timescale 1ns / 1ps
// divider timer with delayed reload: sequencer over one shared tick unit
// depends on dtr_pkg
//
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    tuser req_type, tdata machine_cycles, write_value
// m_axis    out  m_tvalid / m_tready    tdata counter_value, divider_high, irq, pending
// apb       in   psel penable pwrite    paddr, pwdata, prdata
//
// an advance item is accepted in ST_IDLE, runs 4 * machine_cycles divider ticks in the
// tick unit in ST_RUN and is handed to the output register from ST_DONE
// a write item or zero machine cycles goes from ST_IDLE straight to ST_DONE
// the tick unit does one divider tick per clock; s_tready is low while it runs
// a stalled output holds the finished item in the sequencer until taken
// rst_n clears all timer state and registers asynchronously
module divider_timer_with_delayed_reload (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // machine_cycles[3:0], write_value[11:4], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // counter_value[7:0], divider_high[15:8],
                                   // timer_irq[16], reload_pending[17], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                          state_reg;
    logic                            enable_reg;
    logic [1:0]                      select_reg;
    logic [dtr_pkg::CNT_W-1:0]       reload_reg;
    logic [dtr_pkg::DIV_W-1:0]       divider_reg;
    logic [dtr_pkg::CNT_W-1:0]       counter_reg;
    logic [dtr_pkg::CD_W-1:0]        countdown_reg;
    logic [dtr_pkg::CNT_W-1:0]       captured_reg;
    logic [dtr_pkg::TICK_W-1:0]      ticks_reg;
    logic                            irq_reg;
    logic                            m_valid_reg;
    logic [23:0]                     m_data_reg;

    logic [dtr_pkg::DIV_W-1:0]       divider_next;
    logic [dtr_pkg::CNT_W-1:0]       counter_next;
    logic [dtr_pkg::CD_W-1:0]        countdown_next;
    logic [dtr_pkg::CNT_W-1:0]       captured_next;
    logic                            fired;
    logic [3:0]                      bit_idx;
    logic                            s_fire;
    logic                            cfg_wr;
    logic [3:0]                      mc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign mc       = s_tdata[3:0];
    assign bit_idx  = dtr_pkg::edge_bit(select_reg);

    always_comb
    begin
        case (paddr[3:2])
            dtr_pkg::REG_TIMER_ENABLE: prdata = {31'd0, enable_reg};
            dtr_pkg::REG_CLOCK_SELECT: prdata = {30'd0, select_reg};
            dtr_pkg::REG_RELOAD_VALUE: prdata = {24'd0, reload_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // one divider tick
    always_comb
    begin
        counter_next   = counter_reg;
        countdown_next = countdown_reg;
        captured_next  = captured_reg;
        fired          = 1'b0;
        if (countdown_reg != '0)
        begin
            countdown_next = countdown_reg - 1'b1;
            if (countdown_next == '0)
            begin
                counter_next = captured_reg;
                fired        = 1'b1;
            end
            else
            begin
                counter_next = '0;
            end
        end
        divider_next = divider_reg + 1'b1;
        if (enable_reg && divider_reg[bit_idx] && !divider_next[bit_idx])
        begin
            if (counter_next == dtr_pkg::COUNTER_MAX)
            begin
                counter_next   = '0;
                captured_next  = reload_reg;
                countdown_next = dtr_pkg::RELOAD_DELAY;
            end
            else
            begin
                counter_next = counter_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            select_reg    <= '0;
            reload_reg    <= '0;
            divider_reg   <= '0;
            counter_reg   <= '0;
            countdown_reg <= '0;
            captured_reg  <= '0;
            ticks_reg     <= '0;
            irq_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    dtr_pkg::REG_TIMER_ENABLE: enable_reg <= pwdata[0];
                    dtr_pkg::REG_CLOCK_SELECT: select_reg <= pwdata[1:0];
                    dtr_pkg::REG_RELOAD_VALUE: reload_reg <= pwdata[7:0];
                    default:                   ;
                endcase
            end

            if (m_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        irq_reg   <= 1'b0;
                        ticks_reg <= {mc, 2'b00};
                        if (s_tuser == dtr_pkg::REQ_WRITE)
                        begin
                            counter_reg <= s_tdata[11:4];
                            state_reg   <= ST_DONE;
                        end
                        else if (mc == 4'd0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    divider_reg   <= divider_next;
                    counter_reg   <= counter_next;
                    countdown_reg <= countdown_next;
                    captured_reg  <= captured_next;
                    if (fired)
                    begin
                        irq_reg <= 1'b1;
                    end
                    ticks_reg <= ticks_reg - 1'b1;
                    if (ticks_reg == dtr_pkg::TICK_W'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, (countdown_reg != '0), irq_reg,
                                        divider_reg[15:8], counter_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/dtr_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the divider timer with delayed reload, with its bind
// depends only on the top level's ports
module dtr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // the block goes busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an accepted item");

    // a new result only appears after a busy cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without the block being busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("result padding not zero");

endmodule

bind divider_timer_with_delayed_reload dtr_checker u_dtr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/dtr_timer_checker.sv @@
`timescale 1ns / 1ps
// checker for the divider timer: watches the item channels and the apb port,
// predicts each status item from its own copy of the timer and compares them
// depends on dtr_pkg
module dtr_timer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // machine_cycles[3:0], write_value[11:4], zero pad
    input  logic        s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // counter_value[7:0], divider_high[15:8],
                                   // timer_irq[16], reload_pending[17], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    output int unsigned err_cnt,
    output int unsigned outstanding
);

    localparam logic [1:0] TAP_BIT9 = 2'd0;
    localparam logic [1:0] TAP_BIT3 = 2'd1;
    localparam logic [1:0] TAP_BIT5 = 2'd2;
    localparam logic [1:0] TAP_BIT7 = 2'd3;

    typedef struct packed {
        logic [7:0] counter_value;
        logic [7:0] divider_high;
        logic       timer_irq;
        logic       reload_pending;
    } timer_status_t;

    logic                      enable_r;
    logic [1:0]                tap_sel_r;
    logic [7:0]                reload_r;
    logic [dtr_pkg::DIV_W-1:0] div_m;
    logic [dtr_pkg::CNT_W-1:0] count_m;
    logic [dtr_pkg::CD_W-1:0]  countdown_m;
    logic [dtr_pkg::CNT_W-1:0] captured_m;
    timer_status_t             status_q[$];
    int unsigned               errors;

    function automatic int unsigned tap_bit(input logic [1:0] sel);
        int unsigned b;
        case (sel)
            TAP_BIT9: b = 9;
            TAP_BIT3: b = 3;
            TAP_BIT5: b = 5;
            TAP_BIT7: b = 7;
            default:  b = 9;
        endcase
        return b;
    endfunction

    // one divider tick, returns 1 when the delayed reload lands
    function automatic logic tick_timer();
        logic                      fired;
        logic [dtr_pkg::DIV_W-1:0] prev;
        int unsigned               b;
        fired = 1'b0;
        if (countdown_m != '0)
        begin
            countdown_m = countdown_m - 1'b1;
            if (countdown_m == '0)
            begin
                count_m = captured_m;
                fired   = 1'b1;
            end
            else
            begin
                count_m = '0;
            end
        end
        prev  = div_m;
        div_m = div_m + 1'b1;
        b     = tap_bit(tap_sel_r);
        if (enable_r && prev[b] && !div_m[b])
        begin
            if (count_m == dtr_pkg::COUNTER_MAX)
            begin
                count_m     = '0;
                captured_m  = reload_r;
                countdown_m = dtr_pkg::RELOAD_DELAY;
            end
            else
            begin
                count_m = count_m + 1'b1;
            end
        end
        return fired;
    endfunction

    function automatic timer_status_t run_item(input logic req, input logic [3:0] mcyc,
                                               input logic [7:0] wval);
        timer_status_t st;
        logic          irq;
        int unsigned   i;
        irq = 1'b0;
        if (req == dtr_pkg::REQ_ADVANCE)
        begin
            for (i = 0; i < 4 * int'(mcyc); i++)
                if (tick_timer())
                    irq = 1'b1;
        end
        else
        begin
            count_m = wval;
        end
        st.counter_value  = count_m;
        st.divider_high   = div_m[15:8];
        st.timer_irq      = irq;
        st.reload_pending = (countdown_m != '0);
        return st;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        logic [31:0] v;
        case (idx)
            dtr_pkg::REG_TIMER_ENABLE: v = {31'd0, enable_r};
            dtr_pkg::REG_CLOCK_SELECT: v = {30'd0, tap_sel_r};
            dtr_pkg::REG_RELOAD_VALUE: v = {24'd0, reload_r};
            default:                   v = '0;
        endcase
        return v;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_status_t want;
        timer_status_t pred;
        if (!rst_n)
        begin
            enable_r    = 1'b0;
            tap_sel_r   = '0;
            reload_r    = '0;
            div_m       = '0;
            count_m     = '0;
            countdown_m = '0;
            captured_m  = '0;
            errors      = 0;
            status_q.delete();
            err_cnt     <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        dtr_pkg::REG_TIMER_ENABLE: enable_r  = pwdata[0];
                        dtr_pkg::REG_CLOCK_SELECT: tap_sel_r = pwdata[1:0];
                        dtr_pkg::REG_RELOAD_VALUE: reload_r  = pwdata[7:0];
                        default: ;
                    endcase
                end
                else
                begin
                    check_field("prdata", reg_value(paddr[3:2]), prdata);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t unexpected status item: expected none actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("counter_value", 32'(want.counter_value),
                                32'(m_tdata[7:0]));
                    check_field("divider_high", 32'(want.divider_high),
                                32'(m_tdata[15:8]));
                    check_field("timer_irq", 32'(want.timer_irq), 32'(m_tdata[16]));
                    check_field("reload_pending", 32'(want.reload_pending),
                                32'(m_tdata[17]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred = run_item(s_tuser, s_tdata[3:0], s_tdata[11:4]);
                status_q.insert(status_q.size(), pred);
            end
            err_cnt     <= errors;
            outstanding <= status_q.size();
        end
    end

endmodule

@@ tb/sv/divider_timer_with_delayed_reload_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the divider timer: clock, reset, apb setup, item stimulus
// and verdict; depends on dtr_pkg, dtr_timer_checker and the timer rtl
module divider_timer_with_delayed_reload_tb;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // machine_cycles[3:0], write_value[11:4], zero pad
    logic        s_tuser  = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // counter_value[7:0], divider_high[15:8],
                                  // timer_irq[16], reload_pending[17], zero pad
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned err_cnt;
    int unsigned outstanding;
    logic        rx_hold_req  = 1'b0;
    logic        rx_hold_done = 1'b0;
    logic        rx_steady    = 1'b0;

    divider_timer_with_delayed_reload u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dtr_timer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .err_cnt     (err_cnt),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // status receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int unsigned n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done)
            begin
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++)
                    @(posedge clk);
                rx_hold_done <= 1'b1;
            end
            else
            begin
                m_tready <= rx_steady || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_timer(input logic en, input logic [1:0] sel, input logic [7:0] reload);
        apb_access(1'b1, dtr_pkg::REG_TIMER_ENABLE, {31'd0, en});
        apb_access(1'b1, dtr_pkg::REG_CLOCK_SELECT, {30'd0, sel});
        apb_access(1'b1, dtr_pkg::REG_RELOAD_VALUE, {24'd0, reload});
        apb_access(1'b0, dtr_pkg::REG_TIMER_ENABLE, '0);
        apb_access(1'b0, dtr_pkg::REG_CLOCK_SELECT, '0);
        apb_access(1'b0, dtr_pkg::REG_RELOAD_VALUE, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic req, input logic [3:0] mcyc, input logic [7:0] wval);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'd0, wval, mcyc};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the sender until every status item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic random_item();
        logic [7:0] wval;
        wval = $urandom_range(1) ? 8'($urandom_range(255, 248)) : 8'($urandom_range(255));
        if ($urandom_range(99) < 40)
            send_item(dtr_pkg::REQ_WRITE, 4'($urandom_range(15)), wval);
        else
            send_item(dtr_pkg::REQ_ADVANCE, 4'($urandom_range(15)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned k;
        logic [7:0]  reload;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // divider starts at zero: four machine cycles end exactly on the overflow
        set_timer(1'b1, 2'd1, 8'hA5);
        send_item(dtr_pkg::REQ_ADVANCE, 4'd0, 8'h00);
        send_item(dtr_pkg::REQ_WRITE, 4'hF, 8'hFF);
        send_item(dtr_pkg::REQ_ADVANCE, 4'd4, 8'hFF);
        send_item(dtr_pkg::REQ_WRITE, 4'd0, 8'h42);
        send_item(dtr_pkg::REQ_ADVANCE, 4'd0, 8'h00);
        send_item(dtr_pkg::REQ_ADVANCE, 4'd1, 8'h00);
        send_item(dtr_pkg::REQ_WRITE, 4'd0, 8'h00);
        send_item(dtr_pkg::REQ_ADVANCE, 4'hF, 8'hFF);
        send_item(dtr_pkg::REQ_WRITE, 4'hF, 8'hFE);
        send_item(dtr_pkg::REQ_ADVANCE, 4'hF, 8'h00);
        send_item(dtr_pkg::REQ_ADVANCE, 4'hF, 8'hAA);
        send_item(dtr_pkg::REQ_WRITE, 4'h5, 8'h55);
        send_item(dtr_pkg::REQ_WRITE, 4'hA, 8'hAA);
        send_item(dtr_pkg::REQ_ADVANCE, 4'hA, 8'h55);
        send_item(dtr_pkg::REQ_ADVANCE, 4'h5, 8'h00);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            reload = (ph == 0) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom_range(255));
            set_timer(ph != 1, 2'(ph % 4), reload);
            rx_steady <= (ph == 5);
            for (k = 0; k < 192; k++)
            begin
                if (ph == 3 && k == 20)
                    rx_hold_req <= 1'b1;
                if (k % 64 == 63)
                begin
                    drain();
                end
                else if (ph != 5 && $urandom_range(99) < 33)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(6, 1)) @(posedge clk);
                end
                random_item();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (err_cnt == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
